/* hw/rtl/bba_pkg.sv */
`default_nettype none
package bba_pkg;
  localparam int unsigned OrderW = 3;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned CountW = 7;
  localparam logic OpAlloc = 1'b0;
  localparam logic OpQuery = 1'b1;
  localparam logic StOk    = 1'b0;
  localparam logic StNoSpc = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/buddy_block_allocator.sv */
`default_nettype none
// Allocate-only buddy allocator over an address-ordered block list kept in one
// single-port-read synchronous RAM (order and owner per entry). Each entry read
// passes a read and a check state, each entry moved a read and a write state:
// allocate scans the list twice (first exact fit, then first larger free
// block), then each split shifts the tail of the list up by one entry; a
// query emits one result per block, reading the next entry only once the
// previous result has been taken. Writing total_order resets the list;
// entries past the list length are never read.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_ORDER  = 6,
  parameter int unsigned MAX_BLOCKS = 64,
  parameter int unsigned ID_WIDTH   = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [OrderW-1:0]   cfg_total_order_i,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                operation_i,
  input  wire logic [ID_WIDTH-1:0] owner_id_i,
  input  wire logic [SizeW-1:0]    request_size_i,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     status_o,
  output logic [CountW-1:0]        block_count_o,
  output logic [ID_WIDTH-1:0]      block_owner_o,
  output logic                     is_last_o
);
  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned EW = OrderW + ID_WIDTH;
  localparam int unsigned IW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_CK1, S_RD2, S_CK2, S_SPL, S_SRD, S_SWR, S_HALF, S_QRD, S_QCK,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [IW-1:0]     len_q, idx_q, p_q;
  logic [OrderW-1:0] k_q, pord_q;
  logic [ID_WIDTH-1:0] own_q;
  logic              qry_q;
  logic [OrderW-1:0] order0_q;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [EW-1:0]     wdata, rdata;
  logic [OrderW-1:0] r_ord;
  logic [ID_WIDTH-1:0] r_own;

  bba_mem #(.Depth(MAX_BLOCKS), .Width(EW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );
  assign {r_ord, r_own} = rdata;

  // entry 0 lives in flops image via forwarding flag: list reset sets this
  logic init_q;  // entry 0 not yet written since list reset
  logic [EW-1:0] e_rd;
  logic          rd0_q;
  assign e_rd = (rd0_q && init_q) ? {order0_q, {ID_WIDTH{1'b0}}} : rdata;
  logic [OrderW-1:0] e_ord;
  logic [ID_WIDTH-1:0] e_own;
  assign {e_ord, e_own} = e_rd;

  // size to order: smallest k with 2^k >= size
  logic [4:0] kreq;
  always_comb begin
    kreq = 5'd16;
    for (int j = 16; j >= 0; j--) begin
      if ((17'(1) << j) >= {1'b0, request_size_i}) kreq = 5'(j);
    end
  end

  logic [IW-1:0] last_idx;
  assign last_idx = len_q - IW'(1);
  logic [OrderW-1:0] total_sat;
  assign total_sat = (32'(cfg_total_order_i) > MAX_ORDER) ? OrderW'(MAX_ORDER)
                                                          : cfg_total_order_i;

  assign cfg_ready = (state_q == S_IDLE);
  // hold the input outside idle and while a configuration write takes the idle cycle
  assign in_stall  = (state_q != S_IDLE) || cfg_valid;

  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = {r_ord, r_own};
    raddr = idx_q[AW-1:0];
    case (state_q)
      S_CK1: begin
        we = (e_own == '0) && (e_ord == k_q);
        wdata = {k_q, own_q};
      end
      S_SRD: raddr = AW'(idx_q - IW'(1));
      // move entry idx-1, read in S_SRD, up to idx
      S_SWR: begin
        we = 1'b1;
        wdata = e_rd;
      end
      S_HALF: begin
        we = 1'b1;
        waddr = AW'(p_q + IW'(1));
        wdata = {pord_q - OrderW'(1), {ID_WIDTH{1'b0}}};
      end
      S_SPL: begin
        we = (pord_q == k_q);
        waddr = p_q[AW-1:0];
        wdata = {pord_q, own_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= IW'(1);
      idx_q <= '0;
      p_q <= '0;
      k_q <= '0;
      pord_q <= '0;
      own_q <= '0;
      qry_q <= 1'b0;
      order0_q <= OrderW'((MAX_ORDER < 6) ? MAX_ORDER : 6);
      init_q <= 1'b1;
      rd0_q <= 1'b0;
      out_valid <= 1'b0;
      status_o <= StOk;
      block_count_o <= '0;
      block_owner_o <= '0;
      is_last_o <= 1'b0;
    end else begin
      rd0_q <= (raddr == '0);
      if (we && waddr == '0) init_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_valid) begin
            order0_q <= total_sat;
            init_q <= 1'b1;
            len_q <= IW'(1);
          end else if (in_valid) begin
            idx_q <= '0;
            own_q <= owner_id_i;
            k_q <= OrderW'(kreq);
            qry_q <= (operation_i == OpQuery);
            if (operation_i == OpQuery) state_q <= S_QRD;
            else if (32'(kreq) > MAX_ORDER) begin
              status_o <= StNoSpc;
              block_count_o <= CountW'(len_q);
              block_owner_o <= '0;
              is_last_o <= 1'b1;
              out_valid <= 1'b1;
              state_q <= S_OUT;
            end else state_q <= S_RD1;
          end
        end
        S_RD1: state_q <= S_CK1;
        S_CK1: begin
          if (we) begin
            status_o <= StOk;
            block_count_o <= CountW'(len_q);
            block_owner_o <= '0;
            is_last_o <= 1'b1;
            out_valid <= 1'b1;
            state_q <= S_OUT;
          end else if (idx_q == last_idx) begin
            idx_q <= '0;
            state_q <= S_RD2;
          end else begin
            idx_q <= idx_q + IW'(1);
            state_q <= S_RD1;
          end
        end
        S_RD2: state_q <= S_CK2;
        S_CK2: begin
          if (e_own == '0 && e_ord >= k_q) begin
            p_q <= idx_q;
            pord_q <= e_ord;
            if (32'(len_q) + 32'(e_ord - k_q) > MAX_BLOCKS) begin
              status_o <= StNoSpc;
              block_count_o <= CountW'(len_q);
              block_owner_o <= '0;
              is_last_o <= 1'b1;
              out_valid <= 1'b1;
              state_q <= S_OUT;
            end else state_q <= S_SPL;
          end else if (idx_q == last_idx) begin
            status_o <= StNoSpc;
            block_count_o <= CountW'(len_q);
            block_owner_o <= '0;
            is_last_o <= 1'b1;
            out_valid <= 1'b1;
            state_q <= S_OUT;
          end else begin
            idx_q <= idx_q + IW'(1);
            state_q <= S_RD2;
          end
        end
        S_SPL: begin
          if (pord_q == k_q) begin
            status_o <= StOk;
            block_count_o <= CountW'(len_q);
            block_owner_o <= '0;
            is_last_o <= 1'b1;
            out_valid <= 1'b1;
            state_q <= S_OUT;
          end else begin
            idx_q <= len_q;
            state_q <= (len_q > p_q + IW'(1)) ? S_SRD : S_HALF;
          end
        end
        S_SRD: state_q <= S_SWR;
        // move entry idx-1 up to idx
        S_SWR: begin
          idx_q <= idx_q - IW'(1);
          state_q <= (idx_q - IW'(1) > p_q + IW'(1)) ? S_SRD : S_HALF;
        end
        S_HALF: begin
          pord_q <= pord_q - OrderW'(1);
          len_q <= len_q + IW'(1);
          state_q <= S_SPL;
        end
        S_QRD: state_q <= S_QCK;
        S_QCK: begin
          status_o <= StOk;
          block_count_o <= CountW'(len_q);
          block_owner_o <= e_own;
          is_last_o <= (idx_q == last_idx);
          out_valid <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (qry_q && !is_last_o) begin
              idx_q <= idx_q + IW'(1);
              state_q <= S_QRD;
            end else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q >= IW'(1)) && (32'(len_q) <= MAX_BLOCKS)) else $error("list length");
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> state_q == S_OUT) else $error("out_valid outside output state");
  a_len_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HALF) |=> len_q == $past(len_q) + IW'(1)) else $error("split");
  a_alloc_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !qry_q) |-> is_last_o) else $error("alloc result not last");
`endif
endmodule
`default_nettype wire

/* hw/rtl/bba_mem.sv */
`default_nettype none
module bba_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 19
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire
